// ===== rtl/tcc_pkg.sv =====
// shared types and constants for the text console character writer
`default_nettype none
package tcc_pkg;

  localparam int COLUMNS_DEF     = 80;
  localparam int ROWS_DEF        = 25;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] COLOR_RESET = 8'd15;

  // request action codes
  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] CH_NUL     = 8'd0;

  typedef enum logic [2:0] {
    K_CHAR,
    K_NEWLINE,
    K_RETURN,
    K_NULL,
    K_CLEAR,
    K_READ,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  ch;
    logic [4:0]  rrow;
    logic [6:0]  rcol;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic init;
  } back_stat_t;

endpackage
`default_nettype wire

// ===== rtl/tcc_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module tcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/tcc_front.sv =====
// front end: decodes a request into a command for the back end
`default_nettype none
module tcc_front #(
  parameter int COLUMNS = tcc_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcc_pkg::ROWS_DEF
) (
  input  wire logic [1:0]   in_action,
  input  wire logic [7:0]   in_char_code,
  input  wire logic [4:0]   in_read_row,
  input  wire logic [6:0]   in_read_col,
  output tcc_pkg::cmd_t     cmd
);
  import tcc_pkg::*;

  logic rd_ok;

  assign rd_ok = (32'(in_read_row) < ROWS) && (32'(in_read_col) < COLUMNS);

  always_comb begin
    cmd.ch   = in_char_code;
    cmd.rrow = in_read_row;
    cmd.rcol = in_read_col;
    unique case (in_action)
      ACT_PUT: begin
        unique case (in_char_code)
          CH_NEWLINE: cmd.kind = K_NEWLINE;
          CH_RETURN:  cmd.kind = K_RETURN;
          CH_NUL:     cmd.kind = K_NULL;
          default:    cmd.kind = K_CHAR;
        endcase
      end
      ACT_CLEAR: cmd.kind = K_CLEAR;
      // out of range reads answer zero just like the unused code
      ACT_READ:  cmd.kind = rd_ok ? K_READ : K_NOP;
      default:   cmd.kind = K_NOP;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/tcc_queue.sv =====
// short command queue between front and back end
`default_nettype none
module tcc_queue #(
  parameter int DEPTH = tcc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire tcc_pkg::cmd_t   push_data,
  input  wire logic            pop,
  output tcc_pkg::cmd_t        head,
  output tcc_pkg::q_stat_t     stat
);
  import tcc_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

  cmd_t          q_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;

  assign head       = q_r[rd_ptr_r];
  assign stat.full  = (count_r == NW'(DEPTH));
  assign stat.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full && !pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && stat.empty))
    else $error("queue pop while empty");
`endif

endmodule
`default_nettype wire

// ===== rtl/tcc_back.sv =====
// back end: cursor, screen buffer sequencer, scroll and clear sweeps, results
`default_nettype none
module tcc_back #(
  parameter int COLUMNS = tcc_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcc_pkg::ROWS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [7:0]        cfg_data,
  input  wire tcc_pkg::cmd_t     head,
  input  wire tcc_pkg::q_stat_t  q_stat,
  output logic                   pop,
  output tcc_pkg::back_stat_t    stat,
  output logic                   out_strobe,
  output logic      [15:0]       out_cell_data,
  output logic      [4:0]        out_cursor_row,
  output logic      [6:0]        out_cursor_col,
  output logic                   out_scrolled
);
  import tcc_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int CW    = $clog2(COLUMNS + 1);

  localparam logic [AW-1:0] ADDR_LAST = AW'(CELLS - 1);
  localparam logic [AW-1:0] SCROLL_N  = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
  localparam logic [RW-1:0] ROW_END   = RW'(ROWS);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_END   = CW'(COLUMNS);

  typedef enum logic [7:0] {
    S_INIT   = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_EXEC   = 8'b0000_0100,
    S_SCROLL = 8'b0000_1000,
    S_BLANK  = 8'b0001_0000,
    S_APPLY  = 8'b0010_0000,
    S_CLEAR  = 8'b0100_0000,
    S_READ   = 8'b1000_0000
  } state_t;

  state_t        state_r, state_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    color_r;

  logic          strobe_r, strobe_nxt;
  logic [15:0]   cell_r, cell_nxt;
  logic          scr_r, scr_nxt;
  logic [4:0]    orow_r;
  logic [6:0]    ocol_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;

  // cursor after the wrap step of a put
  logic          wrap;
  logic [RW-1:0] row_w;
  logic [CW-1:0] col_w;
  logic          need_scroll;
  logic          is_put;

  // put applied at a normalized cursor
  logic [RW-1:0] a_row, ap_row;
  logic [CW-1:0] a_col, ap_col;
  logic          ap_we;
  logic [AW-1:0] ap_addr;

  tcc_ram #(.WIDTH(16), .DEPTH(CELLS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign wrap        = (col_r >= COL_END);
  assign row_w       = wrap ? row_r + 1'b1 : row_r;
  assign col_w       = wrap ? '0 : col_r;
  assign need_scroll = (row_w >= ROW_END);
  assign is_put      = (cmd_r.kind == K_CHAR) || (cmd_r.kind == K_NEWLINE) ||
                       (cmd_r.kind == K_RETURN) || (cmd_r.kind == K_NULL);

  assign a_row = (state_r == S_APPLY) ? row_r : row_w;
  assign a_col = (state_r == S_APPLY) ? col_r : col_w;

  always_comb begin
    ap_row  = a_row;
    ap_col  = a_col;
    ap_we   = 1'b0;
    ap_addr = AW'(a_row) * COLS_A + AW'(a_col);
    unique case (cmd_r.kind)
      K_CHAR: begin
        ap_we  = 1'b1;
        ap_col = a_col + 1'b1;
      end
      K_NEWLINE: begin
        ap_row = a_row + 1'b1;
        ap_col = '0;
      end
      K_RETURN: ap_col = '0;
      default: ;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    cnt_nxt    = cnt_r;
    pop        = 1'b0;
    strobe_nxt = 1'b0;
    cell_nxt   = '0;
    scr_nxt    = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = cnt_r;
    ram_wdata  = '0;
    ram_raddr  = cnt_r + COLS_A;
    unique case (state_r)
      S_INIT, S_CLEAR: begin
        ram_we = 1'b1;
        if (cnt_r == ADDR_LAST) begin
          state_nxt = S_IDLE;
          if (state_r == S_CLEAR) begin
            row_nxt    = '0;
            col_nxt    = '0;
            strobe_nxt = 1'b1;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          cmd_nxt   = head;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ram_raddr = AW'(cmd_r.rrow) * COLS_A + AW'(cmd_r.rcol);
        if (is_put) begin
          if (need_scroll) begin
            row_nxt   = ROW_LAST;
            col_nxt   = col_w;
            cnt_nxt   = '0;
            state_nxt = S_SCROLL;
          end else begin
            ram_we     = ap_we;
            ram_waddr  = ap_addr;
            ram_wdata  = {color_r, cmd_r.ch};
            row_nxt    = ap_row;
            col_nxt    = ap_col;
            strobe_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else if (cmd_r.kind == K_CLEAR) begin
          cnt_nxt   = '0;
          state_nxt = S_CLEAR;
        end else if (cmd_r.kind == K_READ) begin
          state_nxt = S_READ;
        end else begin
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_SCROLL: begin
        // read runs one cell ahead of the write it feeds
        if (cnt_r != '0) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_r - 1'b1;
          ram_wdata = ram_rdata;
        end
        if (cnt_r == SCROLL_N) begin
          state_nxt = S_BLANK;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_BLANK: begin
        ram_we = 1'b1;
        if (cnt_r == ADDR_LAST) begin
          state_nxt = S_APPLY;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_APPLY: begin
        ram_we     = ap_we;
        ram_waddr  = ap_addr;
        ram_wdata  = {color_r, cmd_r.ch};
        row_nxt    = ap_row;
        col_nxt    = ap_col;
        strobe_nxt = 1'b1;
        scr_nxt    = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_READ: begin
        cell_nxt   = ram_rdata;
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      row_r    <= '0;
      col_r    <= '0;
      cnt_r    <= '0;
      color_r  <= COLOR_RESET;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      cnt_r    <= cnt_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_we) begin
        color_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    if (strobe_nxt) begin
      cell_r <= cell_nxt;
      scr_r  <= scr_nxt;
      orow_r <= 5'(row_nxt);
      ocol_r <= 7'(col_nxt);
    end
  end

  assign stat.init      = (state_r == S_INIT);
  assign out_strobe     = strobe_r;
  assign out_cell_data  = strobe_r ? cell_r : '0;
  assign out_cursor_row = orow_r;
  assign out_cursor_col = ocol_r;
  assign out_scrolled   = strobe_r & scr_r;

`ifndef ASSERT_OFF
  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_SCROLL || state_r == S_BLANK) |=> !strobe_r)
    else $error("result strobe without a finishing state");

  a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r <= ROW_END) && (col_r <= COL_END))
    else $error("cursor out of range");

  a_scroll_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BLANK && cnt_r == ADDR_LAST) |=> (state_r == S_APPLY && row_r == ROW_LAST))
    else $error("scroll did not end on the last row");
`endif

endmodule
`default_nettype wire

// ===== rtl/text_console_char_writer.sv =====
// top level of the text console character writer
//
// Requests enter on in_action, in_char_code, in_read_row and in_read_col and
// are taken at a clock edge with start high and busy low. A put writes one
// character cell with the attribute from the cfg_ register, newline, return
// and nul only move the cursor, clear zeroes the screen and homes the cursor,
// read returns one cell. Every request gives exactly one result, shown for
// one cycle with out_strobe high; the receiver cannot stall it.
// A two entry queue sits between the decoder and the sequencer, so a new
// request is taken while the previous one is still at work.
// Puts without scroll and nops pass through the pop and execute steps of
// the sequencer; a read adds a step for the registered ram read. A put that
// scrolls first copies the screen up one row, one cell a cycle through the
// single ram write port, then blanks the bottom row and applies the put.
// A clear zeroes the screen buffer cell by cell before its result.
// After reset busy stays high while the screen buffer, ROWS*COLUMNS cells
// (2000 by default), is zeroed one cell a cycle; cfg_ writes are taken
// throughout.
`default_nettype none
module text_console_char_writer #(
  parameter int COLUMNS     = tcc_pkg::COLUMNS_DEF,
  parameter int ROWS        = tcc_pkg::ROWS_DEF,
  parameter int QUEUE_DEPTH = tcc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_action,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [4:0]  in_read_row,
  input  wire logic [6:0]  in_read_col,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_data,
  output logic             out_strobe,
  output logic      [15:0] out_cell_data,
  output logic      [4:0]  out_cursor_row,
  output logic      [6:0]  out_cursor_col,
  output logic             out_scrolled
);
  import tcc_pkg::*;

  cmd_t       front_cmd;
  cmd_t       q_head;
  q_stat_t    q_stat;
  back_stat_t back_stat;
  logic       accept;
  logic       pop;

  assign busy   = back_stat.init | q_stat.full;
  assign accept = start & ~busy;

  tcc_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
    .in_action    (in_action),
    .in_char_code (in_char_code),
    .in_read_row  (in_read_row),
    .in_read_col  (in_read_col),
    .cmd          (front_cmd)
  );

  tcc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (front_cmd),
    .pop       (pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  tcc_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .head           (q_head),
    .q_stat         (q_stat),
    .pop            (pop),
    .stat           (back_stat),
    .out_strobe     (out_strobe),
    .out_cell_data  (out_cell_data),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .out_scrolled   (out_scrolled)
  );

endmodule
`default_nettype wire
